>>> src/hsv_pkg.sv
// shared constants and types for the hsv to rgb converter
package hsv_pkg;

    localparam int HUE_W   = 9;
    localparam int CHAN_W  = 8;
    localparam int RAMP_W  = 6;
    localparam int PROD_W  = 16;
    localparam int NUM_W   = 22;
    localparam int RECIP_W = 19;
    localparam int DIV_W   = 14;

    localparam logic [HUE_W-1:0]   DEG_PER_SECTOR = 9'd60;
    localparam logic [HUE_W-1:0]   FULL_CIRCLE    = 9'd360;
    localparam logic [DIV_W-1:0]   DIVISOR        = 14'd15300;
    localparam logic [NUM_W-1:0]   HALF_DIVISOR   = 22'd7650;
    // floor(2^32 / 15300): quotient estimate is exact or one low
    localparam logic [RECIP_W-1:0] RECIP          = 19'd280716;
    localparam int                 RECIP_SHIFT    = 32;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } sector_t;

    // load enables of the pipeline stages
    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
        logic s4_en;
    } pipe_ctrl_t;

endpackage

>>> src/hsv_if.sv
// hsv input channel
interface hsv_if;
    logic       valid;
    logic       ready;
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

>>> src/rgb_if.sv
// rgb output channel
interface rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> src/hsv_sector.sv
// stage 1: hue wrap, sector decode, ramp and saturation times value
module hsv_sector (
    input  logic                          clk,
    input  logic                          en,
    input  logic [hsv_pkg::HUE_W-1:0]     hue,
    input  logic [hsv_pkg::CHAN_W-1:0]    saturation,
    input  logic [hsv_pkg::CHAN_W-1:0]    brightness,
    output hsv_pkg::sector_t              sector,
    output logic [hsv_pkg::RAMP_W-1:0]    ramp,
    output logic [hsv_pkg::PROD_W-1:0]    sv,
    output logic [hsv_pkg::CHAN_W-1:0]    v
);
    import hsv_pkg::*;

    logic [HUE_W-1:0]  hue_wrap;
    logic [HUE_W-1:0]  sec_base;
    logic [HUE_W-1:0]  k_full;
    logic [RAMP_W-1:0] k;
    sector_t           sector_next;
    logic [RAMP_W-1:0] ramp_next;
    sector_t           sector_reg;
    logic [RAMP_W-1:0] ramp_reg;
    logic [PROD_W-1:0] sv_reg;
    logic [CHAN_W-1:0] v_reg;

    assign hue_wrap = (hue >= FULL_CIRCLE) ? hue - FULL_CIRCLE : hue;

    always_comb
    begin
        priority if (hue_wrap >= 9'd300)
        begin
            sector_next = SEC_MAGENTA_RED;
            sec_base    = 9'd300;
        end
        else if (hue_wrap >= 9'd240)
        begin
            sector_next = SEC_BLUE_MAGENTA;
            sec_base    = 9'd240;
        end
        else if (hue_wrap >= 9'd180)
        begin
            sector_next = SEC_CYAN_BLUE;
            sec_base    = 9'd180;
        end
        else if (hue_wrap >= 9'd120)
        begin
            sector_next = SEC_GREEN_CYAN;
            sec_base    = 9'd120;
        end
        else if (hue_wrap >= DEG_PER_SECTOR)
        begin
            sector_next = SEC_YELLOW_GREEN;
            sec_base    = DEG_PER_SECTOR;
        end
        else
        begin
            sector_next = SEC_RED_YELLOW;
            sec_base    = 9'd0;
        end
    end

    assign k_full = hue_wrap - sec_base;
    assign k      = k_full[RAMP_W-1:0];

    // falling ramp on odd sectors
    assign ramp_next = sector_next[0] ? DEG_PER_SECTOR[RAMP_W-1:0] - k : k;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sector_reg <= sector_next;
            ramp_reg   <= ramp_next;
            sv_reg     <= saturation * brightness;
            v_reg      <= brightness;
        end
    end

    assign sector = sector_reg;
    assign ramp   = ramp_reg;
    assign sv     = sv_reg;
    assign v      = v_reg;
endmodule

>>> src/hsv_mix.sv
// stage 2: numerators of the intermediate and zero channels
module hsv_mix (
    input  logic                          clk,
    input  logic                          en,
    input  hsv_pkg::sector_t              sector_in,
    input  logic [hsv_pkg::RAMP_W-1:0]    ramp,
    input  logic [hsv_pkg::PROD_W-1:0]    sv,
    input  logic [hsv_pkg::CHAN_W-1:0]    v_in,
    output hsv_pkg::sector_t              sector,
    output logic [hsv_pkg::NUM_W-1:0]     num_x,
    output logic [hsv_pkg::NUM_W-1:0]     num_z,
    output logic [hsv_pkg::CHAN_W-1:0]    v
);
    import hsv_pkg::*;

    logic [PROD_W-1:0] v255;
    logic [PROD_W-1:0] diff;
    logic [NUM_W-1:0]  base;
    logic [NUM_W-1:0]  ramp_prod;
    sector_t           sector_reg;
    logic [NUM_W-1:0]  num_x_reg;
    logic [NUM_W-1:0]  num_z_reg;
    logic [CHAN_W-1:0] v_reg;

    assign v255 = {v_in, 8'd0} - {8'd0, v_in};
    assign diff = v255 - sv;
    // times 60 as 64 minus 4
    assign base = {diff, 6'd0} - {4'd0, diff, 2'd0};
    assign ramp_prod = NUM_W'(sv) * NUM_W'(ramp);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sector_reg <= sector_in;
            num_x_reg  <= ramp_prod + base;
            num_z_reg  <= base;
            v_reg      <= v_in;
        end
    end

    assign sector = sector_reg;
    assign num_x  = num_x_reg;
    assign num_z  = num_z_reg;
    assign v      = v_reg;
endmodule

>>> src/hsv_div.sv
// rounded division by 15300: reciprocal estimate, then one-step correction
module hsv_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [hsv_pkg::NUM_W-1:0]     num,
    output logic [hsv_pkg::CHAN_W-1:0]    quot
);
    import hsv_pkg::*;

    localparam int EST_W = NUM_W + RECIP_W;

    logic [NUM_W-1:0]  biased;
    logic [EST_W-1:0]  est;
    logic [NUM_W-1:0]  biased_reg;
    logic [CHAN_W-1:0] q0_reg;
    logic [NUM_W-1:0]  back;
    logic [NUM_W-1:0]  rem;

    assign biased = num + HALF_DIVISOR;
    assign est    = EST_W'(biased) * EST_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            biased_reg <= biased;
            q0_reg     <= est[RECIP_SHIFT +: CHAN_W];
        end
    end

    assign back = NUM_W'(q0_reg) * NUM_W'(DIVISOR);
    assign rem  = biased_reg - back;
    // estimate is never high and at most one low
    assign quot = q0_reg + CHAN_W'(rem >= NUM_W'(DIVISOR));
endmodule

>>> src/hsv_to_rgb_converter.sv
// top level of the hsv to rgb converter
// Converts one color per transfer from hue (degrees), saturation and value
// (fractions of 255) to 8-bit red, green and blue, each rounded half up.
// Input channel hsv and output channel rgb use valid/ready; a transfer
// happens on a rising clk edge with valid and ready both high.
// Hue values of 360 and above wrap around the circle.
// An input transfer passes through four register stages (sector decode,
// numerator mix, reciprocal multiply, correction and channel routing) to
// rgb.valid; throughput is one color per cycle while rgb.ready stays high.
// Each stage has its own valid bit and loads when empty or when the stage
// after it moves, so bubbles are squeezed out and input is still taken
// while a result waits, as long as some stage has room.
// When the receiver stalls the pipeline fills and then hsv.ready drops;
// nothing is lost or repeated.
// rst_n (asynchronous, active low) clears all valid bits; no data state.
module hsv_to_rgb_converter (
    input  logic  clk,
    input  logic  rst_n,
    hsv_if.sink   hsv,
    rgb_if.source rgb
);
    import hsv_pkg::*;

    pipe_ctrl_t        ctrl;
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    sector_t           s1_sector;
    logic [RAMP_W-1:0] s1_ramp;
    logic [PROD_W-1:0] s1_sv;
    logic [CHAN_W-1:0] s1_v;
    sector_t           s2_sector;
    logic [NUM_W-1:0]  s2_num_x;
    logic [NUM_W-1:0]  s2_num_z;
    logic [CHAN_W-1:0] s2_v;
    sector_t           s3_sector_reg;
    logic [CHAN_W-1:0] s3_v_reg;
    logic [CHAN_W-1:0] x_val;
    logic [CHAN_W-1:0] z_val;
    logic [CHAN_W-1:0] red_next, green_next, blue_next;
    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg;

    always_comb
    begin
        ctrl.s4_en = !v4_reg || rgb.ready;
        ctrl.s3_en = !v3_reg || ctrl.s4_en;
        ctrl.s2_en = !v2_reg || ctrl.s3_en;
        ctrl.s1_en = !v1_reg || ctrl.s2_en;
    end

    assign hsv.ready = ctrl.s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.s1_en) v1_reg <= hsv.valid;
            if (ctrl.s2_en) v2_reg <= v1_reg;
            if (ctrl.s3_en) v3_reg <= v2_reg;
            if (ctrl.s4_en) v4_reg <= v3_reg;
        end
    end

    hsv_sector u_sector (
        .clk        (clk),
        .en         (ctrl.s1_en),
        .hue        (hsv.hue),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .sector     (s1_sector),
        .ramp       (s1_ramp),
        .sv         (s1_sv),
        .v          (s1_v)
    );

    hsv_mix u_mix (
        .clk       (clk),
        .en        (ctrl.s2_en),
        .sector_in (s1_sector),
        .ramp      (s1_ramp),
        .sv        (s1_sv),
        .v_in      (s1_v),
        .sector    (s2_sector),
        .num_x     (s2_num_x),
        .num_z     (s2_num_z),
        .v         (s2_v)
    );

    hsv_div u_div_x (
        .clk  (clk),
        .en   (ctrl.s3_en),
        .num  (s2_num_x),
        .quot (x_val)
    );

    hsv_div u_div_z (
        .clk  (clk),
        .en   (ctrl.s3_en),
        .num  (s2_num_z),
        .quot (z_val)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.s3_en)
        begin
            s3_sector_reg <= s2_sector;
            s3_v_reg      <= s2_v;
        end
    end

    // chroma channel rounds to the value itself
    always_comb
    begin
        unique case (s3_sector_reg)
            SEC_RED_YELLOW:
            begin
                red_next = s3_v_reg; green_next = x_val; blue_next = z_val;
            end
            SEC_YELLOW_GREEN:
            begin
                red_next = x_val; green_next = s3_v_reg; blue_next = z_val;
            end
            SEC_GREEN_CYAN:
            begin
                red_next = z_val; green_next = s3_v_reg; blue_next = x_val;
            end
            SEC_CYAN_BLUE:
            begin
                red_next = z_val; green_next = x_val; blue_next = s3_v_reg;
            end
            SEC_BLUE_MAGENTA:
            begin
                red_next = x_val; green_next = z_val; blue_next = s3_v_reg;
            end
            default:
            begin
                red_next = s3_v_reg; green_next = z_val; blue_next = x_val;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s4_en)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.valid = v4_reg;
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;
endmodule
